// ===== rtl/gfc_pkg.sv =====
package gfc_pkg;

  localparam int VALUE_BITS = 20;
  localparam int COUNT_BITS = 32;
  localparam int TOTAL_BITS = 32;
  localparam int BYTE_BITS  = 8;
  localparam int FIELD_BITS = 4;
  localparam int CFG_BITS   = 20;
  localparam int RATIO_BITS = 16;
  localparam int CFG_IDX_BITS = 2;
  localparam int SUM_BITS   = VALUE_BITS + 1;
  localparam int NUM_SLOTS  = 5;
  localparam int SLOT_BITS  = $clog2(NUM_SLOTS);

  localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};
  localparam logic [FIELD_BITS-1:0] FIELD_LAST = {FIELD_BITS{1'b1}};

  localparam logic [BYTE_BITS-1:0] CHAR_COLON = 8'h3A;
  localparam logic [BYTE_BITS-1:0] CHAR_TAB   = 8'h09;
  localparam logic [BYTE_BITS-1:0] CHAR_LF    = 8'h0A;
  localparam logic [BYTE_BITS-1:0] CHAR_NUL   = 8'h00;
  localparam logic [BYTE_BITS-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [BYTE_BITS-1:0] CHAR_NINE  = 8'h39;

  localparam logic [SLOT_BITS-1:0] SLOT_QUALITY    = 3'd0;
  localparam logic [SLOT_BITS-1:0] SLOT_REF_PAIRS  = 3'd1;
  localparam logic [SLOT_BITS-1:0] SLOT_ALT_PAIRS  = 3'd2;
  localparam logic [SLOT_BITS-1:0] SLOT_REF_SPLITS = 3'd3;
  localparam logic [SLOT_BITS-1:0] SLOT_ALT_SPLITS = 3'd4;

  localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_ALT_PAIRS = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_RATIO_Q8  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_QUALITY   = 2'd2;

  localparam logic [RATIO_BITS-1:0] RESET_MIN_RATIO = '0;
  localparam logic [CFG_BITS-1:0]   RESET_MIN_ALT   = '0;
  localparam logic [CFG_BITS-1:0]   RESET_MAX_QUAL  = 20'hFFFFF;

  typedef enum logic [1:0] {
    VERDICT_UNCOVERED = 2'd0,
    VERDICT_REJECTED  = 2'd1,
    VERDICT_ACCEPTED  = 2'd2
  } verdict_e;

  typedef struct packed {
    logic                  covered;
    logic                  ref_nonzero;
    logic [SUM_BITS-1:0]   alt_sum;
    logic [SUM_BITS-1:0]   ref_sum;
    logic [VALUE_BITS-1:0] quality;
  } gfc_entry_t;

  typedef struct packed {
    logic [CFG_BITS-1:0]   min_alt_pairs;
    logic [RATIO_BITS-1:0] min_ratio_q8;
    logic [CFG_BITS-1:0]   max_quality;
  } gfc_cfg_t;

  function automatic logic is_term(input logic [BYTE_BITS-1:0] b);
    return (b == CHAR_TAB) || (b == CHAR_LF) || (b == CHAR_NUL);
  endfunction

endpackage

// ===== rtl/gfc_parser.sv =====
module gfc_parser (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [gfc_pkg::BYTE_BITS-1:0]  text_byte_i,
  output logic                           entry_valid_o,
  input  logic                           entry_ready_i,
  output gfc_pkg::gfc_entry_t            entry_o
);
  import gfc_pkg::*;

  localparam int WIDE_BITS = VALUE_BITS + 4;

  logic                  byte_valid_q;
  logic [BYTE_BITS-1:0]  byte_q;
  logic [FIELD_BITS-1:0] field_q, field_d;
  logic                  after_colon_q, after_colon_d;
  logic                  in_number_q, in_number_d;
  logic [VALUE_BITS-1:0] val_q [NUM_SLOTS];
  logic [VALUE_BITS-1:0] val_d [NUM_SLOTS];
  logic                  entry_valid_q;
  gfc_entry_t            entry_q, entry_d;

  logic                  term;
  logic                  entry_free;
  logic                  step;
  logic                  hit;
  logic [SLOT_BITS-1:0]  sel;
  logic                  digit;
  logic                  num_go;
  logic [VALUE_BITS-1:0] base;
  logic [WIDE_BITS-1:0]  wide;
  logic [VALUE_BITS-1:0] next_val;

  assign term       = is_term(byte_q);
  assign entry_free = !entry_valid_q || entry_ready_i;
  assign step       = byte_valid_q && (!term || entry_free);
  assign in_ready_o = !byte_valid_q || step;

  always_comb begin
    hit = 1'b1;
    sel = SLOT_QUALITY;
    case (field_q)
      4'd2: sel = SLOT_QUALITY;
      4'd5: sel = SLOT_REF_PAIRS;
      4'd6: sel = SLOT_ALT_PAIRS;
      4'd7: sel = SLOT_REF_SPLITS;
      4'd8: sel = SLOT_ALT_SPLITS;
      default: hit = 1'b0;
    endcase
  end

  assign digit  = (byte_q >= CHAR_ZERO) && (byte_q <= CHAR_NINE);
  assign num_go = hit && (after_colon_q || in_number_q);
  assign base   = after_colon_q ? '0 : val_q[sel];
  assign wide   = (WIDE_BITS'(base) << 3) + (WIDE_BITS'(base) << 1)
                + WIDE_BITS'(byte_q - CHAR_ZERO);
  assign next_val = (num_go && digit)
                  ? ((wide > WIDE_BITS'(VALUE_MAX)) ? VALUE_MAX : wide[VALUE_BITS-1:0])
                  : '0;

  always_comb begin
    field_d       = field_q;
    after_colon_d = after_colon_q;
    in_number_d   = in_number_q;
    val_d         = val_q;
    entry_d.covered     = (val_q[SLOT_REF_PAIRS] != '0) || (val_q[SLOT_ALT_PAIRS] != '0);
    entry_d.ref_nonzero = (val_q[SLOT_REF_PAIRS] != '0);
    entry_d.alt_sum     = SUM_BITS'(val_q[SLOT_ALT_PAIRS]) + SUM_BITS'(val_q[SLOT_ALT_SPLITS]);
    entry_d.ref_sum     = SUM_BITS'(val_q[SLOT_REF_PAIRS]) + SUM_BITS'(val_q[SLOT_REF_SPLITS]);
    entry_d.quality     = val_q[SLOT_QUALITY];
    if (term) begin
      field_d       = '0;
      after_colon_d = 1'b0;
      in_number_d   = 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        val_d[i] = '0;
      end
    end else begin
      in_number_d = num_go && digit;
      if ((hit && after_colon_q) || (num_go && digit)) begin
        val_d[sel] = next_val;
      end
      after_colon_d = (byte_q == CHAR_COLON);
      if ((byte_q == CHAR_COLON) && (field_q != FIELD_LAST)) begin
        field_d = field_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_valid_q  <= 1'b0;
      field_q       <= '0;
      after_colon_q <= 1'b0;
      in_number_q   <= 1'b0;
      entry_valid_q <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        val_q[i] <= '0;
      end
    end else begin
      if (in_ready_o) begin
        byte_valid_q <= in_valid_i;
      end
      if (step) begin
        field_q       <= field_d;
        after_colon_q <= after_colon_d;
        in_number_q   <= in_number_d;
        val_q         <= val_d;
      end
      if (entry_free) begin
        entry_valid_q <= step && term;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= text_byte_i;
    end
    if (step && term) begin
      entry_q <= entry_d;
    end
  end

  assign entry_valid_o = entry_valid_q;
  assign entry_o       = entry_q;

endmodule

// ===== rtl/gfc_judge.sv =====
module gfc_judge (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  gfc_pkg::gfc_cfg_t              cfg_i,
  input  logic                           entry_valid_i,
  output logic                           entry_ready_o,
  input  gfc_pkg::gfc_entry_t            entry_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [1:0]                     verdict_o,
  output logic [gfc_pkg::TOTAL_BITS-1:0] uncovered_total_o,
  output logic [gfc_pkg::TOTAL_BITS-1:0] rejected_total_o,
  output logic [gfc_pkg::TOTAL_BITS-1:0] accepted_total_o
);
  import gfc_pkg::*;

  localparam int CMP_BITS  = (SUM_BITS > CFG_BITS) ? SUM_BITS + 1 : CFG_BITS + 1;
  localparam int PROD_BITS = RATIO_BITS + SUM_BITS;

  logic                  out_valid_q;
  verdict_e              verdict_q, verdict_d;
  logic [COUNT_BITS-1:0] uncov_q, reject_q, accept_q;
  logic                  load;
  logic [PROD_BITS-1:0]  ratio_rhs;
  logic [PROD_BITS-1:0]  ratio_lhs;
  logic                  few_alt;
  logic                  low_ratio;
  logic                  high_qual;

  assign load          = entry_valid_i && (!out_valid_q || out_ready_i);
  assign entry_ready_o = !out_valid_q || out_ready_i;

  assign ratio_rhs = PROD_BITS'(cfg_i.min_ratio_q8) * PROD_BITS'(entry_i.ref_sum);
  assign ratio_lhs = PROD_BITS'(entry_i.alt_sum) << 8;
  assign few_alt   = CMP_BITS'(entry_i.alt_sum) < CMP_BITS'(cfg_i.min_alt_pairs);
  assign low_ratio = entry_i.ref_nonzero && (ratio_lhs < ratio_rhs);
  assign high_qual = CMP_BITS'(entry_i.quality) > CMP_BITS'(cfg_i.max_quality);

  always_comb begin
    if (!entry_i.covered) begin
      verdict_d = VERDICT_UNCOVERED;
    end else if (few_alt || low_ratio || high_qual) begin
      verdict_d = VERDICT_REJECTED;
    end else begin
      verdict_d = VERDICT_ACCEPTED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      uncov_q     <= '0;
      reject_q    <= '0;
      accept_q    <= '0;
    end else begin
      if (entry_ready_o) begin
        out_valid_q <= entry_valid_i;
      end
      if (load) begin
        case (verdict_d)
          VERDICT_UNCOVERED: uncov_q  <= uncov_q + 1'b1;
          VERDICT_REJECTED:  reject_q <= reject_q + 1'b1;
          default:           accept_q <= accept_q + 1'b1;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      verdict_q <= verdict_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign verdict_o         = verdict_q;
  assign uncovered_total_o = TOTAL_BITS'(uncov_q);
  assign rejected_total_o  = TOTAL_BITS'(reject_q);
  assign accepted_total_o  = TOTAL_BITS'(accept_q);

endmodule

// ===== rtl/genotype_field_classifier.sv =====
// Genotype field classifier.
// Input channel in_valid_i / in_ready_o carries one text byte per item
// (text_byte_i). A tab, newline or NUL ends an entry; every other byte
// updates the field parse and produces no result.
// Output channel out_valid_o / out_ready_i carries one result per entry:
// verdict_o (0 not covered, 1 not valid, 2 valid) and the three running
// totals after that entry.
// Throughput: one byte per cycle while in_ready_o is high, set by the single
// byte-wide parse stage. A result passes from its terminator byte through the
// byte register, then the parse stage into the entry register, then the judge
// stage with its ratio multiply into the output register.
// Thresholds are written through cfg_we_i / cfg_index_i / cfg_data_i, by the
// user only while the block is idle, which is not enforced. Reset clears the
// parse state, the totals and the thresholds (max quality resets to all ones).
// A stalled receiver holds the result; bytes keep flowing until a second
// terminator needs the occupied entry register, then in_ready_o drops.
module genotype_field_classifier (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [gfc_pkg::BYTE_BITS-1:0]     text_byte_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        verdict_o,
  output logic [gfc_pkg::TOTAL_BITS-1:0]    uncovered_total_o,
  output logic [gfc_pkg::TOTAL_BITS-1:0]    rejected_total_o,
  output logic [gfc_pkg::TOTAL_BITS-1:0]    accepted_total_o,
  input  logic                              cfg_we_i,
  input  logic [gfc_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [gfc_pkg::CFG_BITS-1:0]      cfg_data_i
);
  import gfc_pkg::*;

  gfc_cfg_t   cfg_q;
  gfc_entry_t entry;
  logic       entry_valid;
  logic       entry_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_alt_pairs <= RESET_MIN_ALT;
      cfg_q.min_ratio_q8  <= RESET_MIN_RATIO;
      cfg_q.max_quality   <= RESET_MAX_QUAL;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MIN_ALT_PAIRS: cfg_q.min_alt_pairs <= cfg_data_i;
        CFG_MIN_RATIO_Q8:  cfg_q.min_ratio_q8  <= cfg_data_i[RATIO_BITS-1:0];
        CFG_MAX_QUALITY:   cfg_q.max_quality   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  gfc_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .text_byte_i   (text_byte_i),
    .entry_valid_o (entry_valid),
    .entry_ready_i (entry_ready),
    .entry_o       (entry)
  );

  gfc_judge u_judge (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .entry_valid_i     (entry_valid),
    .entry_ready_o     (entry_ready),
    .entry_i           (entry),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .verdict_o         (verdict_o),
    .uncovered_total_o (uncovered_total_o),
    .rejected_total_o  (rejected_total_o),
    .accepted_total_o  (accepted_total_o)
  );

`ifndef NO_ASSERTIONS
  a_verdict_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (verdict_o == VERDICT_UNCOVERED || verdict_o == VERDICT_REJECTED ||
                     verdict_o == VERDICT_ACCEPTED))
    else $error("illegal verdict code");

  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (entry_valid && out_valid_o && !out_ready_i))
    else $error("input stalled without a blocked result");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !entry_valid) |=> !out_valid_o)
    else $error("result repeated after delivery");
`endif

endmodule
